>>> rtl/rv32im_instruction_decoder_top_assert.svh
// ============================================================================
// RV32IM instruction decoder assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ============================================================================
`ifndef RV32IM_INSTRUCTION_DECODER_TOP_ASSERT_SVH
`define RV32IM_INSTRUCTION_DECODER_TOP_ASSERT_SVH

// Same-cycle implication.
`define RV32ID_ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define RV32ID_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/rv32id_pkg.sv
// ============================================================================
// RV32IM instruction decoder package
// Opcode, format and instruction number constants for the decoder.
// ============================================================================
package rv32id_pkg;

	// Major opcodes, bits 6:2 of the instruction word.
	typedef logic [4:0] opcode_t;
	localparam opcode_t OP_LOAD   = 5'h00;
	localparam opcode_t OP_FENCE  = 5'h03;
	localparam opcode_t OP_ALUI   = 5'h04;
	localparam opcode_t OP_AUIPC  = 5'h05;
	localparam opcode_t OP_STORE  = 5'h08;
	localparam opcode_t OP_ALU    = 5'h0C;
	localparam opcode_t OP_LUI    = 5'h0D;
	localparam opcode_t OP_BRANCH = 5'h18;
	localparam opcode_t OP_JALR   = 5'h19;
	localparam opcode_t OP_JAL    = 5'h1B;
	localparam opcode_t OP_SYSTEM = 5'h1C;

	// The two low bits of every 32-bit instruction.
	localparam logic [1:0] LOW_BITS_32 = 2'b11;

	// func7 codes.
	typedef logic [6:0] func7_t;
	localparam func7_t F7_ZERO = 7'h00;
	localparam func7_t F7_MULT = 7'h01;
	localparam func7_t F7_ALT  = 7'h20;

	// Exact bits 31:7 of the environment calls.
	localparam logic [24:0] ECALL_BITS  = 25'h0000000;
	localparam logic [24:0] EBREAK_BITS = 25'h0002000;

	// Instruction format.
	typedef enum logic [2:0] {
		FMT_NONE = 3'd0,
		FMT_R    = 3'd1,
		FMT_I    = 3'd2,
		FMT_S    = 3'd3,
		FMT_B    = 3'd4,
		FMT_U    = 3'd5,
		FMT_J    = 3'd6
	} fmt_t;

	// Instruction numbers.
	typedef logic [5:0] instr_id_t;
	localparam instr_id_t ID_NONE   = 6'd0;
	localparam instr_id_t ID_SLLI   = 6'd1;
	localparam instr_id_t ID_SRLI   = 6'd2;
	localparam instr_id_t ID_SRAI   = 6'd3;
	localparam instr_id_t ID_ADD    = 6'd4;
	localparam instr_id_t ID_SUB    = 6'd5;
	localparam instr_id_t ID_SLL    = 6'd6;
	localparam instr_id_t ID_SLT    = 6'd7;
	localparam instr_id_t ID_SLTU   = 6'd8;
	localparam instr_id_t ID_XOR    = 6'd9;
	localparam instr_id_t ID_SRL    = 6'd10;
	localparam instr_id_t ID_SRA    = 6'd11;
	localparam instr_id_t ID_OR     = 6'd12;
	localparam instr_id_t ID_AND    = 6'd13;
	localparam instr_id_t ID_MUL    = 6'd14;
	localparam instr_id_t ID_MULH   = 6'd15;
	localparam instr_id_t ID_MULHSU = 6'd16;
	localparam instr_id_t ID_MULHU  = 6'd17;
	localparam instr_id_t ID_DIV    = 6'd18;
	localparam instr_id_t ID_DIVU   = 6'd19;
	localparam instr_id_t ID_REM    = 6'd20;
	localparam instr_id_t ID_REMU   = 6'd21;
	localparam instr_id_t ID_FENCE  = 6'd22;
	localparam instr_id_t ID_ECALL  = 6'd23;
	localparam instr_id_t ID_EBREAK = 6'd24;
	localparam instr_id_t ID_JALR   = 6'd25;
	localparam instr_id_t ID_LB     = 6'd26;
	localparam instr_id_t ID_LH     = 6'd27;
	localparam instr_id_t ID_LW     = 6'd28;
	localparam instr_id_t ID_LBU    = 6'd29;
	localparam instr_id_t ID_LHU    = 6'd30;
	localparam instr_id_t ID_ADDI   = 6'd31;
	localparam instr_id_t ID_SLTI   = 6'd32;
	localparam instr_id_t ID_SLTIU  = 6'd33;
	localparam instr_id_t ID_XORI   = 6'd34;
	localparam instr_id_t ID_ORI    = 6'd35;
	localparam instr_id_t ID_ANDI   = 6'd36;
	localparam instr_id_t ID_SB     = 6'd37;
	localparam instr_id_t ID_SH     = 6'd38;
	localparam instr_id_t ID_SW     = 6'd39;
	localparam instr_id_t ID_BEQ    = 6'd40;
	localparam instr_id_t ID_BNE    = 6'd41;
	localparam instr_id_t ID_BLT    = 6'd42;
	localparam instr_id_t ID_BGE    = 6'd43;
	localparam instr_id_t ID_BLTU   = 6'd44;
	localparam instr_id_t ID_BGEU   = 6'd45;
	localparam instr_id_t ID_LUI    = 6'd46;
	localparam instr_id_t ID_AUIPC  = 6'd47;
	localparam instr_id_t ID_JAL    = 6'd48;

	// Decoded result of one instruction word.
	typedef struct packed {
		logic [31:0] imm_value;
		logic [4:0]  src2_reg;
		logic [4:0]  src1_reg;
		logic [4:0]  dest_reg;
		instr_id_t   instr_id;
		fmt_t        format_kind;
	} decode_t;

endpackage

>>> rtl/rv32im_instruction_decoder_top.sv
// ============================================================================
// RV32IM instruction decoder
// Decodes one 32-bit RV32IM word per transaction into format, instruction
// number, register fields and sign-extended immediate.
// ============================================================================
// Usage:
// Instruction words enter on the s_axis channel, one word per transaction.
// Each word gives exactly one decoded transaction on the m_axis channel, in
// order. The word is captured in an input register, decoded by a single pass
// of combinational logic and held in an output register, which drives output
// tvalid once the word has moved on from the input register. A new word is
// taken every cycle while the output is drained, one transaction per cycle
// sustained; the figure is set by the two register stages, each able to
// advance every cycle. When the receiver holds m_axis_tready low, the output
// register keeps its transaction, the input register fills, and then
// s_axis_tready drops until the output is taken; nothing is lost or repeated.
// On reset both stages empty: m_axis_tvalid goes low and s_axis_tready high.
// Words with low bits other than 11 or an unused opcode decode as format 0,
// instruction 0 and immediate 0; register fields always carry their raw bits.
// ============================================================================
`include "rv32im_instruction_decoder_top_assert.svh"

module rv32im_instruction_decoder_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // [31:0] instr_word
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [2:0] format_kind, [8:3] instr_id, [13:9] dest_reg, [18:14] src1_reg,
	// [23:19] src2_reg, [55:24] imm_value
	output logic [55:0] m_axis_tdata
);
	import rv32id_pkg::*;

	logic        valid_s1;
	logic [31:0] word_s1;
	logic        valid_s2;
	decode_t     result_s2;
	logic        load_s1;
	logic        load_s2;
	decode_t     dec;

	logic [4:0]  op;
	logic [2:0]  f3;
	logic [6:0]  f7;
	logic [31:0] imm_i;
	logic [31:0] imm_s;
	logic [31:0] imm_b;
	logic [31:0] imm_u;
	logic [31:0] imm_j;

	// Stage handshake: each stage advances when the one after it has room.
	assign load_s2       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || load_s2;
	assign load_s1       = s_axis_tvalid && s_axis_tready;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			word_s1 <= s_axis_tdata;
		end
	end

	// Field extraction and immediates of every format.
	assign op    = word_s1[6:2];
	assign f3    = word_s1[14:12];
	assign f7    = word_s1[31:25];
	assign imm_i = {{20{word_s1[31]}}, word_s1[31:20]};
	assign imm_s = {{20{word_s1[31]}}, word_s1[31:25], word_s1[11:7]};
	assign imm_b = {{19{word_s1[31]}}, word_s1[31], word_s1[7], word_s1[30:25],
		word_s1[11:8], 1'b0};
	assign imm_u = {word_s1[31:12], 12'h000};
	assign imm_j = {{11{word_s1[31]}}, word_s1[31], word_s1[19:12], word_s1[20],
		word_s1[30:21], 1'b0};

	// Decode of format, instruction number and immediate.
	always_comb begin
		dec             = '0;
		dec.format_kind = FMT_NONE;
		dec.instr_id    = ID_NONE;
		dec.dest_reg    = word_s1[11:7];
		dec.src1_reg    = word_s1[19:15];
		dec.src2_reg    = word_s1[24:20];
		if (word_s1[1:0] == LOW_BITS_32) begin
			unique case (op)
				OP_ALUI: begin
					if (f3 == 3'd1 || f3 == 3'd5) begin
						// Immediate shifts count as R with the shift amount.
						dec.format_kind = FMT_R;
						if (f3 == 3'd1 && f7 == F7_ZERO) begin
							dec.instr_id = ID_SLLI;
						end else if (f3 == 3'd5 && f7 == F7_ZERO) begin
							dec.instr_id = ID_SRLI;
						end else if (f3 == 3'd5 && f7 == F7_ALT) begin
							dec.instr_id = ID_SRAI;
						end
						if (dec.instr_id != ID_NONE) begin
							dec.imm_value = {27'd0, word_s1[24:20]};
						end
					end else begin
						dec.format_kind = FMT_I;
						dec.imm_value   = imm_i;
						unique case (f3)
							3'd0:    dec.instr_id = ID_ADDI;
							3'd2:    dec.instr_id = ID_SLTI;
							3'd3:    dec.instr_id = ID_SLTIU;
							3'd4:    dec.instr_id = ID_XORI;
							3'd6:    dec.instr_id = ID_ORI;
							3'd7:    dec.instr_id = ID_ANDI;
							default: dec.instr_id = ID_NONE;
						endcase
					end
				end
				OP_ALU: begin
					dec.format_kind = FMT_R;
					if (f7 == F7_ZERO) begin
						unique case (f3)
							3'd0:    dec.instr_id = ID_ADD;
							3'd1:    dec.instr_id = ID_SLL;
							3'd2:    dec.instr_id = ID_SLT;
							3'd3:    dec.instr_id = ID_SLTU;
							3'd4:    dec.instr_id = ID_XOR;
							3'd5:    dec.instr_id = ID_SRL;
							3'd6:    dec.instr_id = ID_OR;
							default: dec.instr_id = ID_AND;
						endcase
					end else if (f7 == F7_MULT) begin
						unique case (f3)
							3'd0:    dec.instr_id = ID_MUL;
							3'd1:    dec.instr_id = ID_MULH;
							3'd2:    dec.instr_id = ID_MULHSU;
							3'd3:    dec.instr_id = ID_MULHU;
							3'd4:    dec.instr_id = ID_DIV;
							3'd5:    dec.instr_id = ID_DIVU;
							3'd6:    dec.instr_id = ID_REM;
							default: dec.instr_id = ID_REMU;
						endcase
					end else if (f7 == F7_ALT && f3 == 3'd0) begin
						dec.instr_id = ID_SUB;
					end else if (f7 == F7_ALT && f3 == 3'd5) begin
						dec.instr_id = ID_SRA;
					end
				end
				OP_FENCE: begin
					dec.format_kind = FMT_I;
					dec.imm_value   = imm_i;
					if (f3 == 3'd0) begin
						dec.instr_id = ID_FENCE;
					end
				end
				OP_SYSTEM: begin
					// Environment calls need all of bits 31:7 to match.
					dec.format_kind = FMT_I;
					dec.imm_value   = imm_i;
					if (word_s1[31:7] == ECALL_BITS) begin
						dec.instr_id = ID_ECALL;
					end else if (word_s1[31:7] == EBREAK_BITS) begin
						dec.instr_id = ID_EBREAK;
					end
				end
				OP_JALR: begin
					dec.format_kind = FMT_I;
					dec.imm_value   = imm_i;
					if (f3 == 3'd0) begin
						dec.instr_id = ID_JALR;
					end
				end
				OP_LOAD: begin
					dec.format_kind = FMT_I;
					dec.imm_value   = imm_i;
					unique case (f3)
						3'd0:    dec.instr_id = ID_LB;
						3'd1:    dec.instr_id = ID_LH;
						3'd2:    dec.instr_id = ID_LW;
						3'd4:    dec.instr_id = ID_LBU;
						3'd5:    dec.instr_id = ID_LHU;
						default: dec.instr_id = ID_NONE;
					endcase
				end
				OP_STORE: begin
					dec.format_kind = FMT_S;
					dec.imm_value   = imm_s;
					unique case (f3)
						3'd0:    dec.instr_id = ID_SB;
						3'd1:    dec.instr_id = ID_SH;
						3'd2:    dec.instr_id = ID_SW;
						default: dec.instr_id = ID_NONE;
					endcase
				end
				OP_BRANCH: begin
					dec.format_kind = FMT_B;
					dec.imm_value   = imm_b;
					unique case (f3)
						3'd0:    dec.instr_id = ID_BEQ;
						3'd1:    dec.instr_id = ID_BNE;
						3'd4:    dec.instr_id = ID_BLT;
						3'd5:    dec.instr_id = ID_BGE;
						3'd6:    dec.instr_id = ID_BLTU;
						3'd7:    dec.instr_id = ID_BGEU;
						default: dec.instr_id = ID_NONE;
					endcase
				end
				OP_LUI: begin
					dec.format_kind = FMT_U;
					dec.imm_value   = imm_u;
					dec.instr_id    = ID_LUI;
				end
				OP_AUIPC: begin
					dec.format_kind = FMT_U;
					dec.imm_value   = imm_u;
					dec.instr_id    = ID_AUIPC;
				end
				OP_JAL: begin
					dec.format_kind = FMT_J;
					dec.imm_value   = imm_j;
					dec.instr_id    = ID_JAL;
				end
				default: begin
					dec.format_kind = FMT_NONE;
				end
			endcase
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_axis_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			result_s2 <= dec;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = result_s2;

	// An unknown format carries neither an instruction number nor an immediate.
	`RV32ID_ASSERT_IMPLIES(a_unknown_empty,
		m_axis_tvalid && result_s2.format_kind == FMT_NONE,
		result_s2.instr_id == ID_NONE && result_s2.imm_value == 32'd0,
		"unknown format with nonzero id or immediate")

	// Immediate shifts are R format with a five-bit shift amount.
	`RV32ID_ASSERT_IMPLIES(a_shift_imm,
		m_axis_tvalid && (result_s2.instr_id == ID_SLLI || result_s2.instr_id == ID_SRLI
		|| result_s2.instr_id == ID_SRAI),
		result_s2.format_kind == FMT_R && result_s2.imm_value[31:5] == 27'd0,
		"immediate shift with bad format or shift amount")

	// Upper-immediate instructions have clear low immediate bits.
	`RV32ID_ASSERT_IMPLIES(a_upper_imm,
		m_axis_tvalid && (result_s2.instr_id == ID_LUI || result_s2.instr_id == ID_AUIPC),
		result_s2.format_kind == FMT_U && result_s2.imm_value[11:0] == 12'h000,
		"upper immediate with bad format or low bits")

	// A word held in the input register stays there until the output takes it.
	`RV32ID_ASSERT_NEXT(a_s1_hold,
		valid_s1 && !load_s2,
		valid_s1 && $stable(word_s1),
		"input stage lost its word while stalled")

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// RV32IM instruction decoder testbench
// Streams instruction words into the decoder with random source gaps and
// sink stalls. It predicts each decoded transaction from the word that was
// accepted and compares every field of the output in order of arrival.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rv32id_pkg::*;

	// func3 values that select single instructions.
	localparam logic [2:0] F3_ADD = 3'b000;
	localparam logic [2:0] F3_SLL = 3'b001;
	localparam logic [2:0] F3_SRL = 3'b101;

	// Instruction numbers by func3, entry 7 in the top bits.
	localparam logic [47:0] ALU_BASE_IDS = {ID_AND, ID_OR, ID_SRL, ID_XOR,
		ID_SLTU, ID_SLT, ID_SLL, ID_ADD};
	localparam logic [47:0] ALU_MUL_IDS = {ID_REMU, ID_REM, ID_DIVU, ID_DIV,
		ID_MULHU, ID_MULHSU, ID_MULH, ID_MUL};
	localparam logic [47:0] LOAD_IDS = {ID_NONE, ID_NONE, ID_LHU, ID_LBU,
		ID_NONE, ID_LW, ID_LH, ID_LB};
	localparam logic [47:0] ALUI_IDS = {ID_ANDI, ID_ORI, ID_NONE, ID_XORI,
		ID_SLTIU, ID_SLTI, ID_NONE, ID_ADDI};
	localparam logic [47:0] STORE_IDS = {ID_NONE, ID_NONE, ID_NONE, ID_NONE,
		ID_NONE, ID_SW, ID_SH, ID_SB};
	localparam logic [47:0] BRANCH_IDS = {ID_BGEU, ID_BLTU, ID_BGE, ID_BLT,
		ID_NONE, ID_NONE, ID_BNE, ID_BEQ};

	localparam int RANDOM_WORDS = 1400;
	localparam int MAX_GAP = 13;
	localparam int MAX_REPORTS = 10;

	// One word waiting to be sent; drain holds it back until the output is empty.
	typedef struct packed {
		logic        drain;
		logic [31:0] word;
	} word_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;   // [31:0] instr_word
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	// [2:0] format_kind, [8:3] instr_id, [13:9] dest_reg, [18:14] src1_reg,
	// [23:19] src2_reg, [55:24] imm_value
	logic [55:0] m_axis_tdata;

	word_item_t pending_words[$];
	decode_t    decoded_expect[$];
	int         mismatch_count = 0;
	int         send_gap = 0;
	int         recv_stall = 0;
	bit         send_burst = 1'b0;
	bit         recv_burst = 1'b0;

	rv32im_instruction_decoder_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #2 clk = ~clk;

	// Decodes one word the way the block is meant to.
	function automatic decode_t decode_word(input logic [31:0] w);
		decode_t     d;
		opcode_t     op;
		logic [2:0]  f3;
		func7_t      f7;
		logic [31:0] imm_i;
		op = w[6:2];
		f3 = w[14:12];
		f7 = w[31:25];
		imm_i = {{20{w[31]}}, w[31:20]};
		d.format_kind = FMT_NONE;
		d.instr_id = ID_NONE;
		d.imm_value = '0;
		d.dest_reg = w[11:7];
		d.src1_reg = w[19:15];
		d.src2_reg = w[24:20];
		if (w[1:0] == LOW_BITS_32) begin
			case (op)
				OP_ALUI: begin
					if (f3 == F3_SLL || f3 == F3_SRL) begin
						// Immediate shifts count as R and carry the shift amount.
						d.format_kind = FMT_R;
						if (f3 == F3_SLL && f7 == F7_ZERO)
							d.instr_id = ID_SLLI;
						else if (f3 == F3_SRL && f7 == F7_ZERO)
							d.instr_id = ID_SRLI;
						else if (f3 == F3_SRL && f7 == F7_ALT)
							d.instr_id = ID_SRAI;
						if (d.instr_id != ID_NONE)
							d.imm_value = {27'd0, w[24:20]};
					end else begin
						d.format_kind = FMT_I;
						d.imm_value = imm_i;
						d.instr_id = ALUI_IDS[f3*6 +: 6];
					end
				end
				OP_ALU: begin
					d.format_kind = FMT_R;
					if (f7 == F7_ZERO)
						d.instr_id = ALU_BASE_IDS[f3*6 +: 6];
					else if (f7 == F7_MULT)
						d.instr_id = ALU_MUL_IDS[f3*6 +: 6];
					else if (f7 == F7_ALT && f3 == F3_ADD)
						d.instr_id = ID_SUB;
					else if (f7 == F7_ALT && f3 == F3_SRL)
						d.instr_id = ID_SRA;
				end
				OP_FENCE: begin
					d.format_kind = FMT_I;
					d.imm_value = imm_i;
					if (f3 == F3_ADD)
						d.instr_id = ID_FENCE;
				end
				OP_SYSTEM: begin
					d.format_kind = FMT_I;
					d.imm_value = imm_i;
					if (w[31:7] == ECALL_BITS)
						d.instr_id = ID_ECALL;
					else if (w[31:7] == EBREAK_BITS)
						d.instr_id = ID_EBREAK;
				end
				OP_JALR: begin
					d.format_kind = FMT_I;
					d.imm_value = imm_i;
					if (f3 == F3_ADD)
						d.instr_id = ID_JALR;
				end
				OP_LOAD: begin
					d.format_kind = FMT_I;
					d.imm_value = imm_i;
					d.instr_id = LOAD_IDS[f3*6 +: 6];
				end
				OP_STORE: begin
					d.format_kind = FMT_S;
					d.imm_value = {{20{w[31]}}, w[31:25], w[11:7]};
					d.instr_id = STORE_IDS[f3*6 +: 6];
				end
				OP_BRANCH: begin
					d.format_kind = FMT_B;
					d.imm_value = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
					d.instr_id = BRANCH_IDS[f3*6 +: 6];
				end
				OP_LUI: begin
					d.format_kind = FMT_U;
					d.imm_value = {w[31:12], 12'd0};
					d.instr_id = ID_LUI;
				end
				OP_AUIPC: begin
					d.format_kind = FMT_U;
					d.imm_value = {w[31:12], 12'd0};
					d.instr_id = ID_AUIPC;
				end
				OP_JAL: begin
					d.format_kind = FMT_J;
					d.imm_value = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
					d.instr_id = ID_JAL;
				end
				default: begin
				end
			endcase
		end
		return d;
	endfunction

	// Mostly well-formed words of a known opcode with random content, some noise.
	function automatic logic [31:0] random_word();
		logic [31:0] w;
		int          pick;
		w = $urandom;
		if ($urandom_range(0, 99) < 8)
			return w;
		w[1:0] = LOW_BITS_32;
		pick = $urandom_range(0, 11);
		case (pick)
			0: w[6:2] = OP_LOAD;
			1: w[6:2] = OP_FENCE;
			2: w[6:2] = OP_ALUI;
			3: w[6:2] = OP_AUIPC;
			4: w[6:2] = OP_STORE;
			5: w[6:2] = OP_ALU;
			6: w[6:2] = OP_LUI;
			7: w[6:2] = OP_BRANCH;
			8: w[6:2] = OP_JALR;
			9: w[6:2] = OP_JAL;
			10: w[6:2] = OP_SYSTEM;
			default: begin
			end
		endcase
		// Steer func7 towards the values that name an instruction.
		if ((w[6:2] == OP_ALU || w[6:2] == OP_ALUI) && $urandom_range(0, 3) != 0) begin
			pick = $urandom_range(0, 2);
			w[31:25] = (pick == 0) ? F7_ZERO : (pick == 1) ? F7_MULT : F7_ALT;
		end
		if ((w[6:2] == OP_FENCE || w[6:2] == OP_JALR) && $urandom_range(0, 3) != 0)
			w[14:12] = F3_ADD;
		if (w[6:2] == OP_SYSTEM && $urandom_range(0, 2) == 0)
			w[31:7] = $urandom_range(0, 1) ? EBREAK_BITS : ECALL_BITS;
		return w;
	endfunction

	function automatic int draw_gap(input bit burst);
		return burst ? 0 : $urandom_range(0, MAX_GAP);
	endfunction

	// Source side: presents queued words and records the expected decode of
	// each accepted transaction.
	always @(posedge clk) begin
		bit presenting;
		int gap;
		if (arst_n) begin
			presenting = s_axis_tvalid;
			gap = send_gap;
			if (s_axis_tvalid && s_axis_tready) begin
				decoded_expect.push_back(decode_word(s_axis_tdata));
				presenting = 1'b0;
				if ($urandom_range(0, 63) == 0)
					send_burst = ~send_burst;
				gap = draw_gap(send_burst);
			end
			if (!presenting) begin
				if (gap != 0) begin
					gap = gap - 1;
				end else if (pending_words.size() != 0 &&
						!(pending_words[0].drain && decoded_expect.size() != 0)) begin
					s_axis_tdata <= pending_words[0].word;
					pending_words.pop_front();
					presenting = 1'b1;
				end
			end
			send_gap <= gap;
			s_axis_tvalid <= presenting;
		end
	end

	// Sink side: checks each accepted transaction and stalls at random.
	always @(posedge clk) begin
		bit      rdy;
		int      stall;
		decode_t got;
		decode_t want;
		if (arst_n) begin
			rdy = m_axis_tready;
			stall = recv_stall;
			if (m_axis_tvalid && m_axis_tready) begin
				got = decode_t'(m_axis_tdata);
				if (decoded_expect.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("%0t: unexpected transaction %h", $realtime, m_axis_tdata);
				end else begin
					want = decoded_expect.pop_front();
					if (got.format_kind !== want.format_kind ||
							got.instr_id !== want.instr_id ||
							got.dest_reg !== want.dest_reg ||
							got.src1_reg !== want.src1_reg ||
							got.src2_reg !== want.src2_reg ||
							got.imm_value !== want.imm_value) begin
						mismatch_count++;
						if (mismatch_count <= MAX_REPORTS)
							$display("%0t: mismatch fmt %0d/%0d id %0d/%0d rd %0d/%0d rs1 %0d/%0d rs2 %0d/%0d imm %h/%h (expected/actual)",
								$realtime, want.format_kind, got.format_kind,
								want.instr_id, got.instr_id, want.dest_reg, got.dest_reg,
								want.src1_reg, got.src1_reg, want.src2_reg, got.src2_reg,
								want.imm_value, got.imm_value);
					end
				end
				if ($urandom_range(0, 63) == 0)
					recv_burst = ~recv_burst;
				stall = draw_gap(recv_burst);
				rdy = (stall == 0);
			end else if (!rdy) begin
				if (stall <= 1)
					rdy = 1'b1;
				if (stall > 0)
					stall = stall - 1;
			end
			recv_stall <= stall;
			m_axis_tready <= rdy;
		end
	end

	// Stimulus, reset and end of run.
	initial begin
		logic [31:0] directed[$];
		directed = '{
			32'h0000_0000,   // low bits 00, all zero
			32'hFFFF_FFFF,   // unused opcode, all ones
			32'hFFFF_FFFC,   // low bits 00, all else ones
			32'h0031_00B3,   // add
			32'h4031_00B3,   // sub
			32'h0231_70B3,   // remu
			32'h4031_1033,   // alt func7 on sll, unmatched
			32'h01F1_1093,   // slli by 31
			32'h41F1_5093,   // srai by 31
			32'h0211_5093,   // immediate shift with bad func7
			32'hFFF1_0093,   // addi -1
			32'h8001_2083,   // lw, most negative offset
			32'h0001_3083,   // load with unused func3
			32'hFE11_2FA3,   // sw
			32'h0011_3023,   // store with unused func3
			32'h8000_0063,   // beq, most negative offset
			32'h7E20_FFE3,   // bgeu, largest offset
			32'hFFFF_F0B7,   // lui
			32'h0000_1097,   // auipc
			32'h8000_00EF,   // jal, most negative offset
			32'h0001_10E7,   // jalr with bad func3
			32'h0000_100F,   // fence with bad func3
			32'h0000_0073,   // ecall
			32'h0010_0073,   // ebreak
			32'h3000_1073,   // csr access
			32'h0000_0F73,   // ecall pattern with nonzero rd
			32'h0000_002B    // unused opcode
		};
		foreach (directed[i])
			pending_words.push_back('{drain: 1'b0, word: directed[i]});
		for (int i = 0; i < RANDOM_WORDS; i++)
			pending_words.push_back('{drain: (i % 350 == 0), word: random_word()});

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_words.size() != 0 || s_axis_tvalid)
			@(posedge clk);
		while (decoded_expect.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (decoded_expect.size() != 0)
			mismatch_count++;
		if (mismatch_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#2ms;
		$display("== FAIL ==");
		$finish;
	end

endmodule
